/* rtl/sgbs_pkg.sv */
//------------------------------------------------------------------------------
// sgbs_pkg
// Shared types and constants for the spatial grid bin store.
//------------------------------------------------------------------------------
`default_nettype none
package sgbs_pkg;

  localparam int POS_W  = 24;
  localparam int ID_W   = 16;
  localparam int SCALE_W = 16;
  localparam int OFF_W  = 25;
  localparam int CNT_W  = 3;

  // commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OUT   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_NOTFD = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] REG_CELL_SCALE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP,      // products registered
    S_CHK,      // check bounds, register target cell
    S_CNT,      // count read of target cell
    S_INS,      // insert write or remove start
    S_RM_RD,    // remove: slot read issued
    S_RM_WR,    // remove: compare and compact
    S_RM_END,   // remove: write back count
    S_Q_CELL,   // query: pick neighbour cell
    S_Q_CNT,    // query: count read of neighbour cell
    S_Q_RD,     // query: slot read issued
    S_Q_OUT,    // query: hold handle, emit previous one
    S_Q_END,    // query: final result
    S_RESP      // single result
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item, start map
    logic map_chk;    // register cell coordinates
    logic slot_rd;    // read slot at slot index
    logic ins_wr;     // write id at count, bump count
    logic rm_step;    // compare read slot, maybe copy down
    logic rm_done;    // write back remove count
    logic q_first;    // reset neighbour walk
    logic q_next;     // advance neighbour walk
    logic q_slot_inc; // advance slot within cell
    logic q_hold;     // hold the handle just read
    logic out_set;    // load output register
    logic [2:0] out_status;
    logic out_query;  // output carries the held handle
    logic out_last;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic out_of_grid;
    logic full;
    logic cnt_zero;      // current cell count is zero
    logic slot_last;     // slot index is last below count
    logic rm_hit;        // remove found at least one copy
    logic q_valid_cell;  // neighbour inside grid
    logic q_last_cell;   // ninth neighbour
    logic q_any;         // a handle is held
  } sts_t;

endpackage
`default_nettype wire

/* rtl/sgbs_datapath.sv */
//------------------------------------------------------------------------------
// sgbs_datapath
// Position mapping, cell count and slot storage, neighbour walk, output reg.
//------------------------------------------------------------------------------
`default_nettype none
module sgbs_datapath import sgbs_pkg::*; #(
  parameter int GRID_W = 16,
  parameter int GRID_H = 16,
  parameter int SLOTS  = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [POS_W-1:0] cfg_data,
  input  wire logic [1:0] in_cmd,
  input  wire logic [ID_W-1:0] in_id,
  input  wire logic [POS_W-1:0] in_px,
  input  wire logic [POS_W-1:0] in_py,
  input  wire logic [3:0] in_qx,
  input  wire logic [3:0] in_qy,
  input  wire ctl_t ctl,
  output sts_t sts,
  output logic [2:0] o_status,
  output logic [ID_W-1:0] o_id,
  output logic o_last
);
  localparam int NCELLS = GRID_W * GRID_H;
  localparam int CW = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int XW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int YW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int NSLOT = NCELLS * SLOTS;
  localparam int AW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int PW = OFF_W + SCALE_W;

  // configuration
  logic signed [POS_W-1:0] origin_x, origin_y;
  logic [SCALE_W-1:0] cell_scale;
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      cell_scale <= SCALE_W'(4096);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_CELL_SCALE: cell_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0] cmd;
  logic [ID_W-1:0] id;
  logic [3:0] qx, qy;
  logic signed [OFF_W-1:0] off_x, off_y;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= in_cmd;
      id <= in_id;
      qx <= in_qx;
      qy <= in_qy;
      off_x <= OFF_W'($signed(in_px)) - OFF_W'(origin_x);
      off_y <= OFF_W'($signed(in_py)) - OFF_W'(origin_y);
    end
  end

  // products, one multiplier per axis, registered
  logic [PW-1:0] prod_x, prod_y;
  logic neg_x, neg_y;
  always_ff @(posedge clk) begin
    prod_x <= PW'(off_x[OFF_W-2:0]) * PW'(cell_scale);
    prod_y <= PW'(off_y[OFF_W-2:0]) * PW'(cell_scale);
    neg_x <= off_x[OFF_W-1];
    neg_y <= off_y[OFF_W-1];
  end
  wire [PW-25:0] cx_full = prod_x[PW-1:24];
  wire [PW-25:0] cy_full = prod_y[PW-1:24];
  wire oog = neg_x || neg_y || (cx_full >= (PW-24)'(GRID_W)) ||
             (cy_full >= (PW-24)'(GRID_H));

  // current cell, slot indexes and neighbour walk
  logic [CW-1:0] cur_cell;
  logic [CNT_W-1:0] si, sj;
  logic oog_r;
  logic [1:0] nbx, nby;      // neighbour column and row offset 0..2
  logic hold_v;              // a query handle is held back
  logic [ID_W-1:0] hold_id;
  logic [CNT_W-1:0] cnt_q;
  logic [ID_W-1:0] slot_q;

  // neighbour coordinates
  wire signed [9:0] bx = $signed({6'd0, qx}) - 10'sd1 + $signed({8'd0, nbx});
  wire signed [9:0] by = $signed({6'd0, qy}) - 10'sd1 + $signed({8'd0, nby});
  wire nb_in = (bx >= 10'sd0) && (by >= 10'sd0) &&
               (int'(bx) < GRID_W) && (int'(by) < GRID_H);
  wire [CW-1:0] nb_cell = CW'(int'(bx) * GRID_H + int'(by));

  always_ff @(posedge clk) begin
    if (ctl.map_chk) begin
      oog_r <= oog;
      cur_cell <= CW'(int'(cx_full[XW-1:0]) * GRID_H + int'(cy_full[YW-1:0]));
      si <= '0;
      sj <= '0;
    end
    if (ctl.q_first) begin
      nbx <= '0;
      nby <= '0;
      hold_v <= 1'b0;
    end
    // x-major walk: row offset inner
    if (ctl.q_next) begin
      if (nby == 2'd2) begin
        nby <= '0;
        nbx <= nbx + 2'd1;
      end else begin
        nby <= nby + 2'd1;
      end
      cur_cell <= nb_cell;
      si <= '0;
    end
    if (ctl.q_slot_inc) si <= si + CNT_W'(1);
    if (ctl.q_hold) begin
      hold_id <= slot_q;
      hold_v <= 1'b1;
    end
    if (ctl.rm_step) begin
      si <= si + CNT_W'(1);
      if (slot_q != id) sj <= sj + CNT_W'(1);
    end
  end

  // cell counts with valid bits (reset clears), registered read
  logic [CNT_W-1:0] counts [NCELLS];
  logic [NCELLS-1:0] cvalid;

  always_ff @(posedge clk) begin
    if (rst) cvalid <= '0;
    else if (ctl.ins_wr || ctl.rm_done) cvalid[cur_cell] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (ctl.ins_wr) counts[cur_cell] <= cnt_q + CNT_W'(1);
    else if (ctl.rm_done) counts[cur_cell] <= sj;
    cnt_q <= cvalid[cur_cell] ? counts[cur_cell] : '0;
  end

  // slot memory: one write, one registered read
  logic [ID_W-1:0] slots [NSLOT];
  wire [AW-1:0] rd_addr = AW'(int'(cur_cell) * SLOTS + int'(si));
  wire [AW-1:0] base = AW'(int'(cur_cell) * SLOTS);
  always_ff @(posedge clk) begin
    if (ctl.slot_rd) slot_q <= slots[rd_addr];
    if (ctl.ins_wr) slots[AW'(int'(base) + int'(cnt_q))] <= id;
    else if (ctl.rm_step && slot_q != id) slots[AW'(int'(base) + int'(sj))] <= slot_q;
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.out_set) begin
      o_status <= ctl.out_status;
      o_id <= ctl.out_query ? hold_id : (ctl.out_status == ST_EMPTY ? '0 : id);
      o_last <= ctl.out_last;
    end
  end

  always_comb begin
    sts.cmd = cmd;
    sts.out_of_grid = oog_r;
    sts.full = (int'(cnt_q) >= SLOTS);
    sts.cnt_zero = (cnt_q == '0);
    sts.slot_last = (int'(si) + 1 >= int'(cnt_q));
    sts.rm_hit = (sj != cnt_q);
    sts.q_valid_cell = nb_in;
    sts.q_last_cell = (nbx == 2'd2) && (nby == 2'd2);
    sts.q_any = hold_v;
  end
endmodule
`default_nettype wire

/* rtl/sgbs_ctrl.sv */
//------------------------------------------------------------------------------
// sgbs_ctrl
// Sequencer for insert, remove and neighbourhood query.
//------------------------------------------------------------------------------
`default_nettype none
module sgbs_ctrl import sgbs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output ctl_t ctl
);
  state_t state, state_next;
  logic ov, ov_next;
  logic [2:0] rs_status, rs_status_next;
  logic pend_last, pend_last_next;   // current neighbour is the ninth

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov <= 1'b0;
      rs_status <= ST_OK;
      pend_last <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
      rs_status <= rs_status_next;
      pend_last <= pend_last_next;
    end
  end

  assign out_valid = ov;
  wire out_free = !ov || out_ready;

  always_comb begin
    state_next = state;
    rs_status_next = rs_status;
    pend_last_next = pend_last;
    ov_next = ov && !out_ready;
    ctl = '0;
    in_ready = (state == S_IDLE) && !rst;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          ctl.load = 1'b1;
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        // products are registered at the end of this cycle
        if (sts.cmd == CMD_QUERY) begin
          ctl.q_first = 1'b1;
          state_next = S_Q_CELL;
        end else if (sts.cmd == CMD_INSERT || sts.cmd == CMD_REMOVE) begin
          state_next = S_CHK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHK: begin
        ctl.map_chk = 1'b1;
        state_next = S_CNT;
      end
      S_CNT: state_next = S_INS;
      S_INS: begin
        if (sts.out_of_grid) begin
          rs_status_next = ST_OUT;
          state_next = S_RESP;
        end else if (sts.cmd == CMD_INSERT) begin
          if (sts.full) rs_status_next = ST_FULL;
          else begin
            rs_status_next = ST_OK;
            ctl.ins_wr = 1'b1;
          end
          state_next = S_RESP;
        end else if (sts.cnt_zero) begin
          rs_status_next = ST_NOTFD;
          state_next = S_RESP;
        end else begin
          state_next = S_RM_RD;
        end
      end
      S_RM_RD: begin
        ctl.slot_rd = 1'b1;
        state_next = S_RM_WR;
      end
      S_RM_WR: begin
        ctl.rm_step = 1'b1;
        if (sts.slot_last) state_next = S_RM_END;
        else state_next = S_RM_RD;
      end
      S_RM_END: begin
        ctl.rm_done = 1'b1;
        rs_status_next = sts.rm_hit ? ST_OK : ST_NOTFD;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          ctl.out_set = 1'b1;
          ctl.out_status = rs_status;
          ctl.out_last = 1'b1;
          ov_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_Q_CELL: begin
        ctl.q_next = 1'b1;
        pend_last_next = sts.q_last_cell;
        if (sts.q_valid_cell) state_next = S_Q_CNT;
        else if (sts.q_last_cell) state_next = S_Q_END;
        else state_next = S_Q_CELL;
      end
      S_Q_CNT: state_next = S_Q_RD;
      S_Q_RD: begin
        if (sts.cnt_zero) begin
          state_next = pend_last ? S_Q_END : S_Q_CELL;
        end else begin
          ctl.slot_rd = 1'b1;
          state_next = S_Q_OUT;
        end
      end
      S_Q_OUT: begin
        // the held handle goes out once another one is known to follow
        if (out_free || !sts.q_any) begin
          ctl.q_hold = 1'b1;
          if (sts.q_any) begin
            ctl.out_set = 1'b1;
            ctl.out_status = ST_OK;
            ctl.out_query = 1'b1;
            ov_next = 1'b1;
          end
          if (sts.slot_last) state_next = pend_last ? S_Q_END : S_Q_CELL;
          else begin
            ctl.q_slot_inc = 1'b1;
            state_next = S_Q_RD;
          end
        end
      end
      S_Q_END: begin
        if (out_free) begin
          ctl.out_set = 1'b1;
          ctl.out_query = sts.q_any;
          ctl.out_status = sts.q_any ? ST_OK : ST_EMPTY;
          ctl.out_last = 1'b1;
          ov_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/spatial_grid_bin_store.sv */
//------------------------------------------------------------------------------
// spatial_grid_bin_store
// Uniform grid bin store with insert, remove and 3x3 neighbourhood query.
//------------------------------------------------------------------------------
// channel   dir  handshake        payload
// s_axis    in   tvalid/tready    tdata: command, item_id, pos_x, pos_y, query_x, query_y
// m_axis    out  tvalid/tready    tdata: status, found_id; tlast: last
// cfg       in   cfg_we           cfg_idx, cfg_data
// Insert, and remove on an empty cell or outside the grid, do no slot reads; remove
// otherwise reads and compacts each slot in the cell; query walks the nine neighbours, skips
// those outside the grid and empty cells, and reads each handle of the rest. One item in
// flight at a time; the count and slot memories have registered reads.
// A waiting result stalls the query walk and the final result.
// Reset clears the cell count valid bits; slots need no clearing.
//------------------------------------------------------------------------------
`default_nettype none
module spatial_grid_bin_store import sgbs_pkg::*; #(
  parameter int GRID_W = 16,
  parameter int GRID_H = 16,
  parameter int SLOTS  = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [23:0] cfg_data,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // command[1:0], item_id[17:2], pos_x[41:18], pos_y[65:42], query_x[69:66], query_y[73:70]
  input  wire logic [79:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // status[2:0], found_id[18:3]
  output logic [23:0] m_axis_tdata,
  output logic m_axis_tlast
);
  ctl_t ctl;
  sts_t sts;
  logic [2:0] st;
  logic [ID_W-1:0] fid;
  wire in_fire = s_axis_tvalid && s_axis_tready;

  sgbs_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .sts, .ctl
  );

  sgbs_datapath #(.GRID_W(GRID_W), .GRID_H(GRID_H), .SLOTS(SLOTS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .in_cmd(s_axis_tdata[1:0]), .in_id(s_axis_tdata[17:2]),
    .in_px(s_axis_tdata[41:18]), .in_py(s_axis_tdata[65:42]),
    .in_qx(s_axis_tdata[69:66]), .in_qy(s_axis_tdata[73:70]),
    .ctl, .sts, .o_status(st), .o_id(fid), .o_last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, fid, st};

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> st <= ST_EMPTY) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");
endmodule
`default_nettype wire
